/* rtl/itoaf_pkg.sv */
// Shared definitions for the integer to ASCII formatter.
// Holds the conversion codes, radix selects, character constants and digit lookup.
// No dependencies.
package itoaf_pkg;

    // conversion kinds carried in the input tuser
    localparam logic [2:0] KIND_SDEC  = 3'd0;
    localparam logic [2:0] KIND_UDEC  = 3'd1;
    localparam logic [2:0] KIND_OCT   = 3'd2;
    localparam logic [2:0] KIND_HEXLO = 3'd3;
    localparam logic [2:0] KIND_HEXUP = 3'd4;

    // size modifier codes
    localparam logic [1:0] SMOD_FULL = 2'd0;
    localparam logic [1:0] SMOD_HALF = 2'd1;
    localparam logic [1:0] SMOD_BYTE = 2'd2;

    // default limit on the field width
    localparam int MAX_WIDTH_DEF = 64;

    // fixed item widths
    localparam int VALUE_W = 32;
    localparam int FWIDTH_W = 7;
    localparam int DIGIT_W = 4;
    localparam int NDIG_W = 4;
    localparam int MAX_DIGITS = 11;

    // reciprocal of ten, exact for 32-bit operands after a shift of 35
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP10_SHIFT = 35;

    // ascii characters used besides digits
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // radix select for the digit unit
    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    localparam logic [7:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };
    localparam logic [7:0] HEX_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // character for one digit value
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
        digit_char = upper ? HEX_UPPER[d] : HEX_LOWER[d];
    endfunction

endpackage

/* rtl/itoaf_digit_unit.sv */
// Shared digit unit: one quotient and remainder step by 10, 8 or 16 per load.
// Decimal steps use a reciprocal multiply; the remainder follows from the low bits.
// Depends on itoaf_pkg.
module itoaf_digit_unit (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic [itoaf_pkg::VALUE_W-1:0]        operand,
    input  itoaf_pkg::radix_t                    radix,
    output logic [itoaf_pkg::VALUE_W-1:0]        quotient,
    output logic [itoaf_pkg::DIGIT_W-1:0]        remainder
);

    logic [itoaf_pkg::VALUE_W-1:0]   dividend_reg;
    logic [itoaf_pkg::VALUE_W-1:0]   quot_reg;
    itoaf_pkg::radix_t               radix_reg;
    logic [2*itoaf_pkg::VALUE_W-1:0] product;
    logic [itoaf_pkg::VALUE_W-1:0]   quot_next;
    logic [itoaf_pkg::DIGIT_W-1:0]   qb_low;

    // reciprocal multiply for base ten
    assign product = {{itoaf_pkg::VALUE_W{1'b0}}, operand}
                   * {{itoaf_pkg::VALUE_W{1'b0}}, itoaf_pkg::RECIP10};

    always_comb
    begin
        unique case (radix)
            itoaf_pkg::RADIX_DEC:
                quot_next = {3'b000,
                             product[itoaf_pkg::RECIP10_SHIFT +: itoaf_pkg::VALUE_W - 3]};
            itoaf_pkg::RADIX_OCT: quot_next = operand >> 3;
            itoaf_pkg::RADIX_HEX: quot_next = operand >> 4;
            default:              quot_next = operand >> 4;
        endcase
    end

    // operand and quotient registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dividend_reg <= operand;
            quot_reg     <= quot_next;
            radix_reg    <= radix;
        end
    end

    // low bits of quotient times base, enough for a remainder below 16
    always_comb
    begin
        unique case (radix_reg)
            itoaf_pkg::RADIX_DEC: qb_low = {quot_reg[0], 3'b000} + {quot_reg[2:0], 1'b0};
            itoaf_pkg::RADIX_OCT: qb_low = {quot_reg[0], 3'b000};
            itoaf_pkg::RADIX_HEX: qb_low = '0;
            default:              qb_low = '0;
        endcase
    end

    assign quotient  = quot_reg;
    assign remainder = dividend_reg[itoaf_pkg::DIGIT_W-1:0] - qb_low;

endmodule

/* rtl/integer_to_ascii_formatter_core.sv */
// Top level of the integer to ASCII formatter: input decode, digit sequencer, output stage.
// Instantiates itoaf_digit_unit; uses itoaf_pkg.
//
// channel  | dir | signals                         | payload
// s_axis   | in  | tvalid tready tdata tuser       | one conversion request
// m_axis   | out | tvalid tready tdata tlast       | one character, tlast on the final one
//
// The digit unit yields one digit per cycle.
// The output register sends one character a cycle while the sink is ready.
// tready is high only while idle; a request with an unused kind is taken and dropped.
// Sink stalls hold the character register and pause the emit sequence.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
module integer_to_ascii_formatter_core #(
    parameter int MAX_WIDTH = itoaf_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // value[31:0], size_mod[33:32], zero_pad[34], min_width[41:35], zeros above
    input  logic [47:0] s_axis_tdata,
    // conv_kind[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_char[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int PAD_W = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIG,
        ST_PREP,
        ST_EMIT
    } state_t;

    state_t                               state_reg, state_next;
    logic [itoaf_pkg::VALUE_W-1:0]        mag_reg, mag_next;
    logic                                 neg_reg, neg_next;
    logic                                 upper_reg, upper_next;
    logic                                 zpad_reg, zpad_next;
    itoaf_pkg::radix_t                    radix_reg, radix_next;
    logic [PAD_W-1:0]                     width_reg, width_next;
    logic [PAD_W-1:0]                     pad_reg, pad_next;
    logic [itoaf_pkg::NDIG_W-1:0]         nd_reg, nd_next;
    logic [itoaf_pkg::NDIG_W-1:0]         idx_reg, idx_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [7:0]                           out_char_reg, out_char_next;
    logic                                 out_last_reg, out_last_next;

    logic [itoaf_pkg::DIGIT_W-1:0]        dig_buf [itoaf_pkg::MAX_DIGITS];

    logic [itoaf_pkg::VALUE_W-1:0]        in_value;
    logic [1:0]                           in_smod;
    logic                                 in_zpad;
    logic [itoaf_pkg::FWIDTH_W-1:0]       in_fwidth;
    logic [2:0]                           in_kind;
    logic [itoaf_pkg::VALUE_W-1:0]        cut_value;
    logic                                 sext;

    logic                                 unit_load;
    logic [itoaf_pkg::VALUE_W-1:0]        unit_operand;
    logic [itoaf_pkg::VALUE_W-1:0]        unit_quot;
    logic [itoaf_pkg::DIGIT_W-1:0]        unit_rem;

    logic [PAD_W-1:0]                     text_len;
    logic                                 advance;

    assign in_value  = s_axis_tdata[31:0];
    assign in_smod   = s_axis_tdata[33:32];
    assign in_zpad   = s_axis_tdata[34];
    assign in_fwidth = s_axis_tdata[41:35];
    assign in_kind   = s_axis_tuser;

    // truncate and optionally sign-extend the argument
    assign sext = (in_kind == itoaf_pkg::KIND_SDEC);
    always_comb
    begin
        unique case (in_smod)
            itoaf_pkg::SMOD_HALF: cut_value = {{16{sext & in_value[15]}}, in_value[15:0]};
            itoaf_pkg::SMOD_BYTE: cut_value = {{24{sext & in_value[7]}}, in_value[7:0]};
            default:              cut_value = in_value;
        endcase
    end

    // shared digit unit
    assign unit_load    = (state_reg == ST_LOAD) || ((state_reg == ST_DIG) && (unit_quot != '0));
    assign unit_operand = (state_reg == ST_LOAD) ? mag_reg : unit_quot;

    itoaf_digit_unit u_digit (
        .clk       (clk),
        .load      (unit_load),
        .operand   (unit_operand),
        .radix     (radix_reg),
        .quotient  (unit_quot),
        .remainder (unit_rem)
    );

    assign text_len = PAD_W'(nd_reg) + PAD_W'(neg_reg);
    assign advance  = !out_valid_reg || m_axis_tready;

    // sequencer and output stage next values
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        zpad_next      = zpad_reg;
        radix_next     = radix_reg;
        width_next     = width_reg;
        pad_next       = pad_reg;
        nd_next        = nd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && (in_kind <= itoaf_pkg::KIND_HEXUP))
                begin
                    state_next = ST_LOAD;
                    zpad_next  = in_zpad;
                    upper_next = (in_kind == itoaf_pkg::KIND_HEXUP);
                    neg_next   = sext & cut_value[31];
                    mag_next   = (sext & cut_value[31]) ? (~cut_value + 32'd1) : cut_value;
                    width_next = (in_fwidth > itoaf_pkg::FWIDTH_W'(MAX_WIDTH))
                               ? PAD_W'(MAX_WIDTH) : PAD_W'(in_fwidth);
                    priority if (in_kind == itoaf_pkg::KIND_OCT)
                        radix_next = itoaf_pkg::RADIX_OCT;
                    else if (in_kind >= itoaf_pkg::KIND_HEXLO)
                        radix_next = itoaf_pkg::RADIX_HEX;
                    else
                        radix_next = itoaf_pkg::RADIX_DEC;
                end
            end
            ST_LOAD:
            begin
                nd_next    = '0;
                state_next = ST_DIG;
            end
            ST_DIG:
            begin
                nd_next = nd_reg + 1'b1;
                if (unit_quot == '0)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                pad_next   = (width_reg > text_len) ? (width_reg - text_len) : '0;
                idx_next   = nd_reg - 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    priority if (zpad_reg && neg_reg)
                    begin
                        out_char_next = itoaf_pkg::CHAR_MINUS;
                        neg_next      = 1'b0;
                    end
                    else if (pad_reg != '0)
                    begin
                        out_char_next = zpad_reg ? itoaf_pkg::CHAR_ZERO : itoaf_pkg::CHAR_SPACE;
                        pad_next      = pad_reg - 1'b1;
                    end
                    else if (neg_reg)
                    begin
                        out_char_next = itoaf_pkg::CHAR_MINUS;
                        neg_next      = 1'b0;
                    end
                    else
                    begin
                        out_char_next = itoaf_pkg::digit_char(dig_buf[idx_reg], upper_reg);
                        if (idx_reg == '0)
                        begin
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        upper_reg    <= upper_next;
        zpad_reg     <= zpad_next;
        radix_reg    <= radix_next;
        width_reg    <= width_next;
        pad_reg      <= pad_next;
        nd_reg       <= nd_next;
        idx_reg      <= idx_next;
    end

    // digit buffer, least significant digit first
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIG)
        begin
            dig_buf[nd_reg] <= unit_rem;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* tb/integer_to_ascii_formatter_core_tb.sv */
// Self-checking testbench for integer_to_ascii_formatter_core: directed and random conversions.
// A scoreboard class predicts each character stream; stream transfers are checked in order.
// Depends on itoaf_pkg and the formatter core RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_core_tb;

    // kind and size codes the block does not define
    localparam logic [2:0] KIND_RSVD5 = 3'd5;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;
    localparam logic [1:0] SMOD_RSVD  = 2'd3;

    localparam int RANDOM_CONVS = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [31:0] EDGE_VALUES [8] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_8000, 32'h0000_0080, 32'h0000_FFFF, 32'h0000_007F
    };

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  kind;
        logic [1:0]  smod;
        logic        zpad;
        logic [6:0]  fwidth;
    } conv_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_char_t;

    // predicts the characters of each conversion and checks them in order
    class ascii_scoreboard;
        ascii_char_t expected_chars[$];
        int          n_requests;
        int          n_ignored;
        int          n_chars;
        int          n_mismatch;

        function new();
            n_requests = 0;
            n_ignored  = 0;
            n_chars    = 0;
            n_mismatch = 0;
        endfunction

        function void note_request(input conv_req_t r);
            logic [31:0] mag;
            logic        neg;
            logic        upper;
            int          radix;
            int          nd;
            int          w;
            int          len;
            int          pad;
            logic [7:0]  digs [12];
            logic [7:0]  text [$];
            string       digit_set;
            n_requests++;
            if (r.kind > itoaf_pkg::KIND_HEXUP)
            begin
                n_ignored++;
                return;
            end
            w = (r.fwidth > itoaf_pkg::MAX_WIDTH_DEF) ? itoaf_pkg::MAX_WIDTH_DEF : int'(r.fwidth);
            mag = r.value;
            neg = 1'b0;
            upper = (r.kind == itoaf_pkg::KIND_HEXUP);
            digit_set = upper ? "0123456789ABCDEF" : "0123456789abcdef";

            // cut to the size, sign-extend for signed decimal
            if (r.kind == itoaf_pkg::KIND_SDEC)
            begin
                if (r.smod == itoaf_pkg::SMOD_HALF)
                    mag = {{16{mag[15]}}, mag[15:0]};
                else if (r.smod == itoaf_pkg::SMOD_BYTE)
                    mag = {{24{mag[7]}}, mag[7:0]};
                if (mag[31])
                begin
                    neg = 1'b1;
                    mag = -mag;
                end
                radix = 10;
            end
            else
            begin
                if (r.smod == itoaf_pkg::SMOD_HALF)
                    mag = {16'h0000, mag[15:0]};
                else if (r.smod == itoaf_pkg::SMOD_BYTE)
                    mag = {24'h000000, mag[7:0]};
                radix = (r.kind == itoaf_pkg::KIND_UDEC) ? 10
                      : (r.kind == itoaf_pkg::KIND_OCT) ? 8 : 16;
            end

            // digits, least significant first
            nd = 0;
            do
            begin
                digs[nd] = digit_set[mag % radix];
                nd++;
                mag = mag / radix;
            end
            while (mag != 0 && nd < 12);

            len = nd + (neg ? 1 : 0);
            pad = (w > len) ? w - len : 0;

            // zero padding goes after the sign, space padding before it
            if (r.zpad)
            begin
                if (neg)
                    text.push_back(itoaf_pkg::CHAR_MINUS);
                repeat (pad) text.push_back(itoaf_pkg::CHAR_ZERO);
            end
            else
            begin
                repeat (pad) text.push_back(itoaf_pkg::CHAR_SPACE);
                if (neg)
                    text.push_back(itoaf_pkg::CHAR_MINUS);
            end
            for (int i = nd - 1; i >= 0; i--)
                text.push_back(digs[i]);

            foreach (text[i])
                expected_chars.push_back('{text[i], i == text.size() - 1});
        endfunction

        function void check_char(input logic [7:0] ch, input logic last);
            ascii_char_t want;
            n_chars++;
            if (expected_chars.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("ERROR: unexpected char 0x%02h last=%0b at %0t", ch, last, $time);
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch || last !== want.last)
            begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("ERROR: char %0d expected 0x%02h last=%0b, got 0x%02h last=%0b",
                             n_chars, want.ch, want.last, ch, last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    ascii_scoreboard ascii_sb;
    int              burst_left = 0;

    integer_to_ascii_formatter_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // offer one conversion, with a random gap at the start of each burst
    task automatic send_conv(input logic [31:0] value, input logic [2:0] kind,
                             input logic [1:0] smod, input logic zpad,
                             input logic [6:0] fwidth);
        conv_req_t r;
        int        gap;
        r = '{value, kind, smod, zpad, fwidth};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, fwidth, zpad, smod, value};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        ascii_sb.note_request(r);
    endtask

    // output transfers checked as they happen
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ascii_sb.check_char(m_axis_tdata, m_axis_tlast);
    end

    // sink backpressure: changing stall modes plus one long hold-off
    initial
    begin : sink_stall
        sink_mode_t mode;
        int         mode_left;
        int         cyc;
        bit         held;
        mode = SINK_OPEN;
        mode_left = 0;
        cyc = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && ascii_sb.n_requests >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:     m_axis_tready <= 1'b1;
                    SINK_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                    SINK_PERIODIC: m_axis_tready <= (cyc % 3 != 0);
                    default:       m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("integer_to_ascii_formatter_core_tb NOT OK");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int          n_conv;
        logic [31:0] v;
        logic [2:0]  kind;
        logic [6:0]  fw;
        ascii_sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every kind, special cases
        send_conv(32'h0000_0000, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_FULL, 1'b0, 7'd0);
        send_conv(32'h8000_0000, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_FULL, 1'b0, 7'd0);
        send_conv(32'h8000_0000, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_FULL, 1'b1, 7'd14);
        send_conv(32'h7FFF_FFFF, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_FULL, 1'b0, 7'd11);
        send_conv(32'hFFFF_FFFF, itoaf_pkg::KIND_UDEC,  itoaf_pkg::SMOD_FULL, 1'b0, 7'd0);
        send_conv(32'hFFFF_FFFF, itoaf_pkg::KIND_OCT,   itoaf_pkg::SMOD_FULL, 1'b0, 7'd0);
        send_conv(32'hDEAD_BEEF, itoaf_pkg::KIND_HEXLO, itoaf_pkg::SMOD_FULL, 1'b1, 7'd12);
        send_conv(32'hDEAD_BEEF, itoaf_pkg::KIND_HEXUP, itoaf_pkg::SMOD_FULL, 1'b0, 7'd12);
        send_conv(32'h1234_8000, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_HALF, 1'b1, 7'd10);
        send_conv(32'h0000_0080, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_BYTE, 1'b0, 7'd8);
        send_conv(32'h0000_007F, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_BYTE, 1'b1, 7'd4);
        send_conv(32'h0000_7FFF, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_HALF, 1'b0, 7'd0);
        send_conv(32'hABCD_12FF, itoaf_pkg::KIND_UDEC,  itoaf_pkg::SMOD_BYTE, 1'b1, 7'd127);
        send_conv(32'hFFFF_FFFF, itoaf_pkg::KIND_SDEC,  itoaf_pkg::SMOD_FULL, 1'b0, 7'd64);
        send_conv(32'h0000_0000, itoaf_pkg::KIND_HEXUP, itoaf_pkg::SMOD_FULL, 1'b1, 7'd64);
        send_conv(32'hCAFE_F00D, itoaf_pkg::KIND_HEXLO, SMOD_RSVD,            1'b0, 7'd1);
        send_conv(32'hFFFF_FFFF, itoaf_pkg::KIND_OCT,   itoaf_pkg::SMOD_HALF, 1'b0, 7'd65);
        send_conv(32'd12345,     itoaf_pkg::KIND_UDEC,  itoaf_pkg::SMOD_FULL, 1'b1, 7'd5);
        send_conv(32'd123456,    itoaf_pkg::KIND_UDEC,  itoaf_pkg::SMOD_FULL, 1'b0, 7'd3);
        send_conv(32'h1234_5678, KIND_RSVD5,            itoaf_pkg::SMOD_FULL, 1'b0, 7'd20);
        send_conv(32'h1234_5678, KIND_RSVD6,            itoaf_pkg::SMOD_HALF, 1'b1, 7'd8);
        send_conv(32'h1234_5678, KIND_RSVD7,            itoaf_pkg::SMOD_BYTE, 1'b0, 7'd127);
        send_conv(32'hFFFF_FF80, itoaf_pkg::KIND_SDEC,  SMOD_RSVD,            1'b1, 7'd0);

        // random conversions; unused kinds are mixed in but not counted
        n_conv = 0;
        while (n_conv < RANDOM_CONVS)
        begin
            case ($urandom_range(0, 5))
                0, 1:    v = $urandom;
                2:       v = $urandom_range(0, 999);
                3:       v = EDGE_VALUES[$urandom_range(0, 7)];
                4:       v = $urandom | 32'hFFFF_FF00;
                default: v = $urandom >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 9))
                7, 8:    fw = 7'($urandom_range(0, 64));
                9:       fw = 7'($urandom_range(65, 127));
                default: fw = 7'($urandom_range(0, 20));
            endcase
            kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            send_conv(v, kind, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), fw);
            if (kind <= itoaf_pkg::KIND_HEXUP)
                n_conv++;
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding characters, then let the block settle
        while (ascii_sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests (%0d with unused kinds), %0d characters checked",
                 ascii_sb.n_requests, ascii_sb.n_ignored, ascii_sb.n_chars);
        $display("mismatches: %0d, characters still pending: %0d",
                 ascii_sb.n_mismatch, ascii_sb.expected_chars.size());
        if (ascii_sb.n_mismatch == 0 && ascii_sb.expected_chars.size() == 0)
            $display("integer_to_ascii_formatter_core_tb OK");
        else
            $display("integer_to_ascii_formatter_core_tb NOT OK");
        $finish;
    end

endmodule
